// File: rtl/tamt_pkg.sv
// Shared types and constants for the two-axis move-to-target block.
`timescale 1ns / 1ps
package tamt_pkg;

   localparam int SPEED_W  = 12;
   localparam int OPCODE_W = 2;
   localparam logic [SPEED_W-1:0] SPEED_RESET = 12'd256;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PLACE = 2'd0,
      OP_AIM   = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_DIV,
      ST_RESP
   } state_type;

endpackage

// File: rtl/tamt_if.sv
// Channel interfaces: command, result and speed register write.
`timescale 1ns / 1ps
interface tamt_req_if #(parameter int COORD_BITS = 12);
   logic                          valid;
   logic                          ready;
   logic [tamt_pkg::OPCODE_W-1:0] opcode;
   logic [COORD_BITS-1:0]         target_x;
   logic [COORD_BITS-1:0]         target_y;

   modport source (output valid, output opcode, output target_x, output target_y,
                   input ready);
   modport sink   (input valid, input opcode, input target_x, input target_y,
                   output ready);
endinterface

interface tamt_rsp_if #(parameter int POS_BITS = 20);
   logic                valid;
   logic                ready;
   logic [POS_BITS-1:0] pos_x;
   logic [POS_BITS-1:0] pos_y;
   logic                is_moving;

   modport source (output valid, output pos_x, output pos_y, output is_moving,
                   input ready);
   modport sink   (input valid, input pos_x, input pos_y, input is_moving,
                   output ready);
endinterface

interface tamt_csr_if;
   logic                         valid;
   logic                         ready;
   logic [tamt_pkg::SPEED_W-1:0] speed;

   modport source (output valid, output speed, input ready);
   modport sink   (input valid, input speed, output ready);
endinterface

// File: rtl/tamt_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tamt_div #(
   parameter int DEN_W  = 12,
   parameter int QUOT_W = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DEN_W+QUOT_W-1:0]   num,
   input  logic [DEN_W-1:0]          den,
   output logic                      busy,
   output logic                      done,
   output logic [QUOT_W-1:0]         quot
);
   // The caller guarantees num < den << QUOT_W, so the quotient fits QUOT_W bits
   // and the upper part of num already is a valid partial remainder.
   localparam int NUM_W = DEN_W + QUOT_W;
   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           fits;

   always_comb begin
      trial = {rem_ff, q_ff[QUOT_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
   end

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num[NUM_W-1:QUOT_W];
         q_in    = num[QUOT_W-1:0];
         den_in  = den;
         cnt_in  = CNT_W'(QUOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         q_in   = {q_ff[QUOT_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;

endmodule

// File: rtl/two_axis_move_to_target.sv
// Top level: point mover with place, aim and tick commands.
`timescale 1ns / 1ps
// Holds a fixed-point position (COORD_BITS integer, FRAC_BITS fraction bits), a
// whole-pixel target and per-axis steps. Each command transaction returns one
// result transaction with the position and the moving flag. Place, tick and the
// unused opcode pass from accept through the decode and response states. Aim
// passes through decode, multiply, divide and response; the restoring divider
// produces one bit of the minor-axis step per cycle, and an aim with zero
// distance skips the divider. A result stalled by rsp ready adds its wait to
// the command behind it. The block takes one command at a time; req ready is
// high only between commands, and a finished result waits in an output register
// while the next command is accepted. The speed register can be written at any
// time but should only change while idle.
module two_axis_move_to_target #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 8
) (
   input logic         clock,
   input logic         reset,
   tamt_req_if.sink    req_bus,
   tamt_rsp_if.source  rsp_bus,
   tamt_csr_if.sink    csr_bus
);
   localparam int POS_W = COORD_BITS + FRAC_BITS;
   localparam int SPD_W = tamt_pkg::SPEED_W;
   localparam int NUM_W = COORD_BITS + SPD_W;

   tamt_pkg::state_type state_ff, state_in;

   logic [SPD_W-1:0]      speed_ff;
   tamt_pkg::op_type      op_ff, op_in;
   logic [COORD_BITS-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [POS_W-1:0]      cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [SPD_W-1:0]      step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic                  moving_ff, moving_in;
   logic [COORD_BITS-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic                  x_major_ff, x_major_in;
   logic [POS_W-1:0]      rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                  rsp_mv_ff, rsp_mv_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  accept, div_start, rsp_load, any_dist, div_busy, div_done;
   logic [SPD_W-1:0]      quot;
   logic [NUM_W-1:0]      product;
   logic [COORD_BITS-1:0] div_den;
   logic                  x_major;
   logic [POS_W:0]        adv_x, adv_y;

   function automatic logic [COORD_BITS-1:0] whole_dist(input logic [POS_W-1:0] p,
                                                        input logic [COORD_BITS-1:0] goal);
      logic [POS_W-1:0] g;
      logic [POS_W-1:0] d;
      g = {goal, {FRAC_BITS{1'b0}}};
      d = (p > g) ? (p - g) : (g - p);
      return d[POS_W-1:FRAC_BITS];
   endfunction

   // {moved, new position}
   function automatic logic [POS_W:0] advance(input logic [POS_W-1:0] p,
                                              input logic [COORD_BITS-1:0] goal,
                                              input logic [SPD_W-1:0] step);
      logic [POS_W-1:0] g;
      logic [POS_W-1:0] s;
      logic [POS_W:0]   r;
      g = {goal, {FRAC_BITS{1'b0}}};
      s = POS_W'(step);
      if (p < g) begin
         r = {1'b1, ((g - p) < s) ? g : (p + s)};
      end else if (p > g) begin
         r = {1'b1, ((p - g) < s) ? g : (p - s)};
      end else begin
         r = {1'b0, p};
      end
      return r;
   endfunction

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tamt_pkg::ST_IDLE:   if (req_bus.valid) state_in = tamt_pkg::ST_DECODE;
         tamt_pkg::ST_DECODE: begin
            state_in = (op_ff == tamt_pkg::OP_AIM) ? tamt_pkg::ST_MUL : tamt_pkg::ST_RESP;
         end
         tamt_pkg::ST_MUL:    state_in = any_dist ? tamt_pkg::ST_DIV : tamt_pkg::ST_RESP;
         tamt_pkg::ST_DIV:    if (div_done) state_in = tamt_pkg::ST_RESP;
         tamt_pkg::ST_RESP:   if (!rsp_valid_ff || rsp_bus.ready) state_in = tamt_pkg::ST_IDLE;
         default:             state_in = tamt_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      accept    = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         tamt_pkg::ST_IDLE: accept    = req_bus.valid;
         tamt_pkg::ST_MUL:  div_start = any_dist;
         tamt_pkg::ST_RESP: rsp_load  = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   assign req_bus.ready = (state_ff == tamt_pkg::ST_IDLE) && !reset;
   assign csr_bus.ready = !reset;

   // Major axis gets full speed; ties go to y, which still yields speed on x.
   assign any_dist = (dx_ff != '0) || (dy_ff != '0);
   assign x_major  = dx_ff > dy_ff;
   assign product  = NUM_W'(x_major ? dy_ff : dx_ff) * NUM_W'(speed_ff);
   assign div_den  = x_major ? dx_ff : dy_ff;
   assign adv_x    = advance(cur_x_ff, goal_x_ff, step_x_ff);
   assign adv_y    = advance(cur_y_ff, goal_y_ff, step_y_ff);

   tamt_div #(
      .DEN_W  (COORD_BITS),
      .QUOT_W (SPD_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (product),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      op_in        = op_ff;
      tgt_x_in     = tgt_x_ff;
      tgt_y_in     = tgt_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      moving_in    = moving_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      x_major_in   = x_major_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_mv_in    = rsp_mv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      if (accept) begin
         op_in    = tamt_pkg::op_type'(req_bus.opcode);
         tgt_x_in = req_bus.target_x;
         tgt_y_in = req_bus.target_y;
      end

      if (state_ff == tamt_pkg::ST_DECODE) begin
         case (op_ff)
            tamt_pkg::OP_PLACE: begin
               cur_x_in  = {tgt_x_ff, {FRAC_BITS{1'b0}}};
               cur_y_in  = {tgt_y_ff, {FRAC_BITS{1'b0}}};
               goal_x_in = tgt_x_ff;
               goal_y_in = tgt_y_ff;
               moving_in = 1'b0;
            end
            tamt_pkg::OP_AIM: begin
               goal_x_in = tgt_x_ff;
               goal_y_in = tgt_y_ff;
               dx_in     = whole_dist(cur_x_ff, tgt_x_ff);
               dy_in     = whole_dist(cur_y_ff, tgt_y_ff);
               moving_in = 1'b1;
            end
            tamt_pkg::OP_TICK: begin
               if (moving_ff) begin
                  cur_x_in  = adv_x[POS_W-1:0];
                  cur_y_in  = adv_y[POS_W-1:0];
                  moving_in = adv_x[POS_W] || adv_y[POS_W];
               end
            end
            default: ;
         endcase
      end

      if (state_ff == tamt_pkg::ST_MUL) begin
         x_major_in = x_major;
         if (!any_dist) begin
            step_x_in = '0;
            step_y_in = '0;
         end else if (x_major) begin
            step_x_in = speed_ff;
         end else begin
            step_y_in = speed_ff;
         end
      end

      if (div_done) begin
         if (x_major_ff) step_y_in = quot;
         else step_x_in = quot;
      end

      if (rsp_load) begin
         rsp_x_in     = cur_x_ff;
         rsp_y_in     = cur_y_ff;
         rsp_mv_in    = moving_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tamt_pkg::ST_IDLE;
         speed_ff     <= tamt_pkg::SPEED_RESET;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         step_x_ff    <= '0;
         step_y_ff    <= '0;
         moving_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_bus.valid) speed_ff <= csr_bus.speed;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         step_x_ff    <= step_x_in;
         step_y_ff    <= step_y_in;
         moving_ff    <= moving_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      tgt_x_ff   <= tgt_x_in;
      tgt_y_ff   <= tgt_y_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      x_major_ff <= x_major_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_mv_ff  <= rsp_mv_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.pos_x     = rsp_x_ff;
   assign rsp_bus.pos_y     = rsp_y_ff;
   assign rsp_bus.is_moving = rsp_mv_ff;

   // Divider only runs while the sequencer waits on it
   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == tamt_pkg::ST_DIV)
      else $error("divider finished outside the divide state");

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == tamt_pkg::ST_IDLE |-> !div_busy)
      else $error("divider busy while idle");

   a_aim_sets_moving: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tamt_pkg::ST_DECODE && op_ff == tamt_pkg::OP_AIM) |=> moving_ff)
      else $error("aim did not set the moving flag");

   a_place_clears_moving: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tamt_pkg::ST_DECODE && op_ff == tamt_pkg::OP_PLACE) |=> !moving_ff)
      else $error("place left the moving flag set");

endmodule
